[design/bln_pkg.sv]
`default_nettype none
package bln_pkg;

  localparam int ROWS    = 16;
  localparam int COLUMNS = 32;
  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int CNT_W   = $clog2(ROWS + 1);
  // per-column agree minus disagree, spans -ROWS .. ROWS
  localparam int DIFF_W  = $clog2(ROWS) + 2;

  typedef enum logic [2:0] {
    KIND_WR_WEIGHT = 3'd0,
    KIND_WR_BIAS   = 3'd1,
    KIND_FORWARD   = 3'd2,
    KIND_BACKWARD  = 3'd3,
    KIND_READ      = 3'd4
  } kind_e;

  typedef logic signed [7:0] wt_t;
  typedef wt_t [COLUMNS-1:0] wrow_t;

  typedef struct packed {
    logic [6:0]   pad;
    logic [15:0]  down_rows;
    logic [15:0]  zero_rows;
    logic [31:0]  activations;
    wt_t          weight_value;
    logic [4:0]   column;
    logic [3:0]   row;
  } in_t;

  typedef struct packed {
    wt_t          bias_readback;
    wt_t          weight_readback;
    logic [31:0]  next_sign;
    logic [31:0]  next_zero;
    logic [15:0]  layer_out;
  } out_t;

  // operands of one row pass through the shared row unit
  typedef struct packed {
    logic [COLUMNS-1:0] sign_row;
    logic [COLUMNS-1:0] act;
    logic               bias_sign;
    logic               down;
    wt_t                bias;
  } alu_req_t;

  typedef struct packed {
    logic               fwd_bit;
    logic [COLUMNS-1:0] agree;
    logic [COLUMNS-1:0] sign_row;
    wt_t                bias;
    logic               bias_sign;
  } alu_rsp_t;

  // population count of one column word
  function automatic logic [5:0] popcount32(input logic [31:0] v);
    logic [31:0] a, b, c, d, e;
    a = v - ((v >> 1) & 32'h5555_5555);
    b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
    c = (b + (b >> 4)) & 32'h0f0f_0f0f;
    d = c + (c >> 8);
    e = d + (d >> 16);
    return e[5:0];
  endfunction

  // step of -1 or +1, held at the ends of the 8-bit range
  function automatic wt_t nudge(input wt_t v, input logic down);
    wt_t r;
    if (down) begin
      r = (v == -8'sd128) ? v : v - 8'sd1;
    end else begin
      r = (v == 8'sd127) ? v : v + 8'sd1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[design/bln_row_alu.sv]
`default_nettype none
module bln_row_alu
  import bln_pkg::*;
(
  input  alu_req_t req_i,
  input  wrow_t    weights_i,
  output alu_rsp_t rsp_o,
  output wrow_t    weights_o
);

  logic [5:0] pos_cnt, neg_cnt;
  logic [6:0] pos_sum, neg_sum;

  assign pos_cnt = popcount32(req_i.act & req_i.sign_row);
  assign neg_cnt = popcount32(req_i.act & ~req_i.sign_row);
  assign pos_sum = {1'b0, pos_cnt} + {6'd0, req_i.bias_sign};
  assign neg_sum = {1'b0, neg_cnt} + {6'd0, ~req_i.bias_sign};

  always_comb begin
    rsp_o.fwd_bit   = pos_sum > neg_sum;
    rsp_o.agree     = ~(req_i.sign_row ^ {COLUMNS{req_i.down}});
    rsp_o.bias      = nudge(req_i.bias, req_i.down);
    rsp_o.bias_sign = rsp_o.bias > 8'sd0;
    for (int j = 0; j < COLUMNS; j++) begin
      weights_o[j]      = req_i.act[j] ? nudge(weights_i[j], req_i.down) : weights_i[j];
      rsp_o.sign_row[j] = weights_o[j] > 8'sd0;
    end
  end

endmodule
`default_nettype wire

[design/binary_layer_forward_backward.sv]
`default_nettype none
// Binarised fully connected layer, 16 neurons by 32 inputs, with signed 8-bit latent weights and
// biases kept beside their sign bits. Every item gives exactly one result. Write weight does a
// read-modify-write and read does a registered read of one weight row. For forward and backward
// the sequencer walks the rows one per cycle through a single shared row unit (two popcounts and a
// compare for forward, 32 saturating nudges and the per-column agreement for backward), and the
// backward pass is one stage longer for the registered read of the row memory. The input side is
// not ready while an item is in work; a finished result waits in the output register, so the next
// item can be taken meanwhile. Reset clears the whole store at once through per-row valid bits,
// with no sweep.
module binary_layer_forward_backward
  import bln_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // row[3:0], column[8:4], weight_value[16:9], activations[48:17],
  // zero_rows[64:49], down_rows[80:65], zero fill[87:81]
  input  wire logic [87:0] s_axis_tdata_i,
  // kind[2:0]
  input  wire logic [2:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // layer_out[15:0], next_zero[47:16], next_sign[79:48],
  // weight_readback[87:80], bias_readback[95:88]
  output logic [95:0]      m_axis_tdata_o
);

  // one-hot sequencer
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_WRW  = 6'b000010,
    S_RDW  = 6'b000100,
    S_FWD  = 6'b001000,
    S_BWD  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;
  in_t    in_item;
  logic   in_accept, out_free;

  assign in_item         = in_t'(s_axis_tdata_i);
  assign s_axis_tready_o = state_q == S_IDLE;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_axis_tvalid_o || m_axis_tready_i;

  // item held for the whole pass
  kind_e              kind_q;
  logic [ROW_W-1:0]   row_q;
  logic [COL_W-1:0]   col_q;
  wt_t                val_q;
  logic [COLUMNS-1:0] act_q;
  logic [ROWS-1:0]    gz_q, gs_q;

  // sequencer counter and backward pipeline stage
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               pv_q, pv_d;
  logic [ROW_W-1:0]   row_p_q, row_p_d;

  // store: weight rows in memory, signs and biases in flops
  wrow_t              mem [ROWS];
  wrow_t              rd_q;
  logic [ROW_W-1:0]   raddr;
  logic               mem_we;
  logic [ROW_W-1:0]   waddr;
  wrow_t              wdata;
  logic [ROWS-1:0]    rv_q;
  logic [COLUMNS-1:0] sign_rows_q [ROWS];
  wt_t                bias_q [ROWS];
  logic [ROWS-1:0]    bias_sign_q;

  // result work registers
  logic [ROWS-1:0]           lo_q;
  logic signed [DIFF_W-1:0]  diff_q [COLUMNS];
  wt_t                       wr_q, br_q;
  out_t                      out_q;
  logic                      m_valid_q;

  // shared row unit
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  wrow_t            alu_w_out;
  wrow_t            row_data;
  logic [ROW_W-1:0] alu_row;

  // a row never written reads as all zero
  assign row_data = rv_q[alu_row] ? rd_q : '0;

  always_comb begin
    alu_row           = (state_q == S_FWD) ? cnt_q[ROW_W-1:0] : row_p_q;
    alu_req.sign_row  = sign_rows_q[alu_row];
    alu_req.act       = act_q;
    alu_req.bias_sign = bias_sign_q[alu_row];
    alu_req.down      = gs_q[alu_row];
    alu_req.bias      = bias_q[alu_row];
  end

  bln_row_alu u_row_alu (
    .req_i     (alu_req),
    .weights_i (row_data),
    .rsp_o     (alu_rsp),
    .weights_o (alu_w_out)
  );

  // read address: the item's row on accept, else the sequencer row
  assign raddr = (state_q == S_IDLE) ? in_item.row : cnt_q[ROW_W-1:0];

  always_comb begin
    mem_we = 1'b0;
    waddr  = row_p_q;
    wdata  = alu_w_out;
    if (state_q == S_WRW) begin
      mem_we        = 1'b1;
      waddr         = row_q;
      wdata         = rv_q[row_q] ? rd_q : '0;
      wdata[col_q]  = val_q;
    end else if (pv_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pv_d    = 1'b0;
    row_p_d = row_p_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cnt_d = '0;
          unique case (kind_e'(s_axis_tuser_i))
            KIND_WR_WEIGHT: state_d = S_WRW;
            KIND_FORWARD:   state_d = S_FWD;
            KIND_BACKWARD:  state_d = S_BWD;
            KIND_READ:      state_d = S_RDW;
            default:        state_d = S_DONE;
          endcase
        end
      end
      S_WRW, S_RDW: state_d = S_DONE;
      S_FWD: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ROWS - 1)) begin
          state_d = S_DONE;
        end
      end
      S_BWD: begin
        if (cnt_q < CNT_W'(ROWS)) begin
          // rows with a zero gradient pass by without an update
          cnt_d   = cnt_q + CNT_W'(1);
          pv_d    = !gz_q[cnt_q[ROW_W-1:0]];
          row_p_d = cnt_q[ROW_W-1:0];
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pv_q    <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_p_q <= row_p_d;
    if (in_accept) begin
      kind_q <= kind_e'(s_axis_tuser_i);
      row_q  <= in_item.row;
      col_q  <= in_item.column;
      val_q  <= in_item.weight_value;
      act_q  <= in_item.activations;
      gz_q   <= in_item.zero_rows;
      gs_q   <= in_item.down_rows;
    end
  end

  // sign rows, biases and row valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q        <= '0;
      bias_sign_q <= '0;
      for (int i = 0; i < ROWS; i++) begin
        sign_rows_q[i] <= '0;
        bias_q[i]      <= '0;
      end
    end else begin
      if (in_accept && kind_e'(s_axis_tuser_i) == KIND_WR_BIAS) begin
        bias_q[in_item.row]      <= in_item.weight_value;
        bias_sign_q[in_item.row] <= in_item.weight_value > 8'sd0;
      end
      if (state_q == S_WRW) begin
        rv_q[row_q]               <= 1'b1;
        sign_rows_q[row_q][col_q] <= val_q > 8'sd0;
      end
      if (pv_q) begin
        rv_q[row_p_q]        <= 1'b1;
        sign_rows_q[row_p_q] <= alu_rsp.sign_row;
        bias_q[row_p_q]      <= alu_rsp.bias;
        bias_sign_q[row_p_q] <= alu_rsp.bias_sign;
      end
    end
  end

  // result work registers, cleared on accept
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      lo_q <= '0;
      wr_q <= '0;
      br_q <= '0;
      for (int j = 0; j < COLUMNS; j++) begin
        diff_q[j] <= '0;
      end
    end else begin
      if (state_q == S_FWD) begin
        lo_q[cnt_q[ROW_W-1:0]] <= alu_rsp.fwd_bit;
      end
      if (state_q == S_RDW) begin
        wr_q <= rv_q[row_q] ? rd_q[col_q] : 8'sd0;
        br_q <= bias_q[row_q];
      end
      if (pv_q) begin
        // signs seen here are those before this row's update
        for (int j = 0; j < COLUMNS; j++) begin
          diff_q[j] <= alu_rsp.agree[j] ? diff_q[j] + DIFF_W'(1) : diff_q[j] - DIFF_W'(1);
        end
      end
    end
  end

  // output register
  out_t out_d;
  always_comb begin
    out_d                 = '0;
    out_d.layer_out       = lo_q;
    out_d.weight_readback = wr_q;
    out_d.bias_readback   = br_q;
    if (kind_q == KIND_BACKWARD) begin
      for (int j = 0; j < COLUMNS; j++) begin
        out_d.next_zero[j] = diff_q[j] == '0;
        out_d.next_sign[j] = diff_q[j] > $signed(DIFF_W'(0));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_q;

  // backward stage is only live inside the backward pass
  a_pv_in_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> state_q == S_BWD)
    else $error("row update outside backward pass");

  // the row read ahead is never the row being written back
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pv_q && cnt_q < CNT_W'(ROWS)) |-> row_p_q != cnt_q[ROW_W-1:0])
    else $error("read and write of the same weight row");

  // memory is written only by a weight write or a backward row update
  a_we_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_WRW) || pv_q)
    else $error("stray weight memory write");

  // a finished item reaches the output register
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (m_axis_tvalid_o && state_q == S_IDLE))
    else $error("result not presented");

endmodule
`default_nettype wire
